### sv/iee_pkg.sv
// Package: shared types and constants for the infix expression evaluator
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIVZERO   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic       vpush;      // push imm value
        logic [3:0] imm;
        logic       opush;      // push operator
        t_op        op;
        logic       opop;       // drop top operator
        logic       red_start;  // begin a reduction of top operator
        logic       rd_start;   // load tops into read registers
        logic       clear;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic vfull;
        logic ofull;
        logic oempty;
        logic vlt2;
        logic vone;
        t_op  top;
        logic tops_ok;    // top registers valid
        logic red_busy;
        logic red_done;
        logic red_divz;
    } t_sts;

    function automatic logic [1:0] rank_of(t_op op);
        return (op == OP_MUL || op == OP_DIV) ? 2'd2 : 2'd1;
    endfunction

endpackage

### sv/iee_ram.sv
// Generic single-write, single-read RAM with registered read
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### sv/iee_alu.sv
// Iterative ALU: add/sub computed on start, shift-add multiply and restoring divide iterate over all 32 bits
module iee_alu
    import iee_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_op         i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_busy,
    output logic        o_done,
    output logic        o_divz,
    output logic [31:0] o_res
);
    logic        r_busy, r_done, r_divz, r_neg;
    t_op         r_op;
    logic [4:0]  r_cnt;
    logic [31:0] r_acc, r_x, r_y, r_rem;
    logic [32:0] w_trial;
    logic [31:0] w_shrem;

    assign w_shrem = {r_rem[30:0], r_x[31]};
    assign w_trial = {1'b0, w_shrem} - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_op   <= i_op;
                r_divz <= 1'b0;
                r_cnt  <= 5'd0;
                r_acc  <= 32'd0;
                r_rem  <= 32'd0;
                case (i_op)
                    OP_ADD: begin r_acc <= i_a + i_b; r_done <= 1'b1; end
                    OP_SUB: begin r_acc <= i_a - i_b; r_done <= 1'b1; end
                    OP_MUL: begin r_x <= i_a; r_y <= i_b; r_busy <= 1'b1; end
                    OP_DIV: begin
                        if (i_b == 32'd0) begin
                            r_divz <= 1'b1;
                            r_done <= 1'b1;
                        end else begin
                            r_x    <= i_a[31] ? 32'd0 - i_a : i_a;
                            r_y    <= i_b[31] ? 32'd0 - i_b : i_b;
                            r_neg  <= i_a[31] ^ i_b[31];
                            r_busy <= 1'b1;
                        end
                    end
                    default: r_done <= 1'b1;
                endcase
            end else if (r_busy) begin
                if (r_op == OP_MUL) begin
                    if (r_y[0]) r_acc <= r_acc + r_x;
                    r_x <= {r_x[30:0], 1'b0};
                    r_y <= {1'b0, r_y[31:1]};
                end else begin
                    // shift quotient into r_x as dividend bits leave
                    if (!w_trial[32]) begin
                        r_rem <= w_trial[31:0];
                        r_x   <= {r_x[30:0], 1'b1};
                    end else begin
                        r_rem <= w_shrem;
                        r_x   <= {r_x[30:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_op == OP_DIV) o_res = r_neg ? 32'd0 - r_x : r_x;
        else                o_res = r_acc;
    end
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_divz = r_divz;
endmodule

### sv/iee_datapath.sv
// Datapath: value and operator stacks in RAM, top-of-stack registers, ALU
module iee_datapath
    import iee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [31:0] o_bottom
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0] r_vcnt, r_ocnt;
    logic [31:0]   w_vr;
    logic [2:0]    w_or;
    logic          v_we, o_we;
    logic [AW-1:0] v_wa, v_ra, o_wa, o_ra;
    logic [31:0]   v_wd;
    logic [1:0]    r_rdph;
    logic [31:0]   r_a, r_b;
    t_op           r_top;
    logic          r_ok, r_red;
    logic          alu_busy, alu_done, alu_divz;
    logic [31:0]   alu_res;
    logic          w_chg;

    // reads: phase 1 reads b (vcnt-1) and top op, phase 2 reads a (vcnt-2)
    always_comb begin
        v_ra = r_vcnt[AW-1:0] - AW'(1);
        if (r_rdph == 2'd2) v_ra = r_vcnt[AW-1:0] - AW'(2);
        if (r_rdph == 2'd0) v_ra = '0;
        o_ra = r_ocnt[AW-1:0] - AW'(1);
    end

    iee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_vram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(w_vr));
    iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_oram (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_wa), .i_wdata(i_cmd.op),
        .i_raddr(o_ra), .o_rdata(w_or));

    iee_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.red_start), .i_op(r_top),
        .i_a(r_a), .i_b(r_b), .o_busy(alu_busy), .o_done(alu_done),
        .o_divz(alu_divz), .o_res(alu_res));

    always_comb begin
        v_we = i_cmd.vpush || (alu_done && !alu_divz);
        v_wa = r_vcnt[AW-1:0];
        v_wd = {28'd0, i_cmd.imm};
        if (alu_done) begin
            v_wa = r_vcnt[AW-1:0] - AW'(2);
            v_wd = alu_res;
        end
        o_we = i_cmd.opush;
        o_wa = r_ocnt[AW-1:0];
    end

    // any stack change makes the top registers stale
    assign w_chg = i_cmd.vpush || i_cmd.opush || i_cmd.opop || alu_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
            r_ocnt <= '0;
            r_rdph <= 2'd0;
            r_ok   <= 1'b0;
            r_red  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_vcnt <= '0;
                r_ocnt <= '0;
                r_ok   <= 1'b0;
                r_rdph <= 2'd0;
            end else begin
                if (i_cmd.vpush) r_vcnt <= r_vcnt + CW'(1);
                if (i_cmd.opush) r_ocnt <= r_ocnt + CW'(1);
                if (i_cmd.opop)  r_ocnt <= r_ocnt - CW'(1);
                if (alu_done && !alu_divz) begin
                    r_vcnt <= r_vcnt - CW'(1);
                    r_ocnt <= r_ocnt - CW'(1);
                end
                if (i_cmd.rd_start) begin
                    r_rdph <= 2'd1;
                    r_ok   <= 1'b0;
                end else if (r_rdph == 2'd1) begin
                    r_rdph <= 2'd2;
                end else if (r_rdph == 2'd2) begin
                    r_b    <= w_vr;
                    r_top  <= t_op'(w_or);
                    r_rdph <= 2'd3;
                end else if (r_rdph == 2'd3) begin
                    r_a    <= w_vr;
                    r_rdph <= 2'd0;
                    r_ok   <= !w_chg;
                end else if (w_chg) begin
                    r_ok   <= 1'b0;
                end
            end
            r_red <= i_cmd.red_start;
        end
    end

    assign o_sts.vfull    = (r_vcnt >= CW'(STACK_DEPTH));
    assign o_sts.ofull    = (r_ocnt >= CW'(STACK_DEPTH));
    assign o_sts.oempty   = (r_ocnt == '0);
    assign o_sts.vlt2     = (r_vcnt < CW'(2));
    assign o_sts.vone     = (r_vcnt == CW'(1));
    assign o_sts.top      = r_top;
    assign o_sts.tops_ok  = r_ok;
    assign o_sts.red_busy = alu_busy || r_red;
    assign o_sts.red_done = alu_done;
    assign o_sts.red_divz = alu_divz;
    assign o_bottom       = r_b;
endmodule

### sv/iee_ctrl.sv
// Controller: sequences character handling, reductions, draining and result
module iee_ctrl
    import iee_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_in   i_data,
    output t_cmd  o_cmd,
    input  t_sts  i_sts,
    input  logic [31:0] i_bottom,
    output logic  o_valid,
    input  logic  i_stall,
    output t_out  o_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DECIDE, S_RED, S_FIN, S_OUT
    } t_state;

    t_state      r_state;
    logic [7:0]  r_ch;
    logic        r_last;
    logic [1:0]  r_err;
    logic        r_drain;   // draining at end of expression
    logic        r_ovalid;
    t_out        r_out;
    t_op         w_newop;
    logic        w_isop;
    t_cmd        w_cmd;
    t_state      n_state;
    logic [1:0]  n_err;
    logic        n_drain;

    assign w_isop = (r_ch == CH_ADD) || (r_ch == CH_SUB) ||
                    (r_ch == CH_MUL) || (r_ch == CH_DIV);
    always_comb begin
        case (r_ch)
            CH_ADD:  w_newop = OP_ADD;
            CH_SUB:  w_newop = OP_SUB;
            CH_MUL:  w_newop = OP_MUL;
            default: w_newop = OP_DIV;
        endcase
    end

    function automatic logic [1:0] first_err(logic [1:0] cur, t_status code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    // next state and commands; in S_DECIDE tops hold the operator and both values unless the op stack is empty
    always_comb begin
        w_cmd   = '0;
        w_cmd.imm = 4'(r_ch - CH_ZERO);
        w_cmd.op  = w_newop;
        n_state = r_state;
        n_err   = r_err;
        n_drain = r_drain;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = (r_err != ST_OK) ? S_FIN : S_READ;
            end
            S_READ: begin
                if (i_sts.tops_ok || i_sts.oempty) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_err != ST_OK) begin
                    n_state = S_FIN;
                end else if (r_drain) begin
                    if (i_sts.oempty) n_state = S_FIN;
                    else if (i_sts.top == OP_LPAREN) begin
                        n_err = ST_MALFORMED; n_state = S_FIN;
                    end else n_state = S_RED;
                end else if (r_ch >= CH_ZERO && r_ch <= CH_NINE) begin
                    if (i_sts.vfull) n_err = ST_OVERFLOW;
                    else w_cmd.vpush = 1'b1;
                    n_state = S_FIN;
                end else if (r_ch == CH_LPAREN) begin
                    if (i_sts.ofull) n_err = ST_OVERFLOW;
                    else begin w_cmd.opush = 1'b1; w_cmd.op = OP_LPAREN; end
                    n_state = S_FIN;
                end else if (r_ch == CH_RPAREN) begin
                    if (i_sts.oempty) begin
                        n_err = ST_MALFORMED; n_state = S_FIN;
                    end else if (i_sts.top == OP_LPAREN) begin
                        w_cmd.opop = 1'b1; n_state = S_FIN;
                    end else n_state = S_RED;
                end else if (w_isop) begin
                    if (!i_sts.oempty && i_sts.top != OP_LPAREN &&
                        rank_of(w_newop) <= rank_of(i_sts.top)) begin
                        n_state = S_RED;
                    end else begin
                        if (i_sts.ofull) n_err = ST_OVERFLOW;
                        else w_cmd.opush = 1'b1;
                        n_state = S_FIN;
                    end
                end else n_state = S_FIN;
                if (n_state == S_RED) begin
                    if (i_sts.vlt2) begin
                        n_err = ST_MALFORMED; n_state = S_FIN;
                    end else w_cmd.red_start = 1'b1;
                end
            end
            S_RED: begin
                if (i_sts.red_done) begin
                    if (i_sts.red_divz) begin
                        n_err = first_err(r_err, ST_DIVZERO); n_state = S_FIN;
                    end else begin
                        w_cmd.rd_start = 1'b1; n_state = S_READ;
                    end
                end
            end
            S_FIN: begin
                if (r_last && !r_drain && r_err == ST_OK) begin
                    n_drain = 1'b1; w_cmd.rd_start = 1'b1; n_state = S_READ;
                end else if (r_last) begin
                    if (r_err == ST_OK && !i_sts.vone) n_err = ST_MALFORMED;
                    // bottom value needs a fresh read
                    w_cmd.rd_start = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_sts.tops_ok && !r_ovalid) begin
                    w_cmd.clear = 1'b1; n_state = S_IDLE;
                    n_err   = ST_OK;
                    n_drain = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // every non-last character starts a top read in S_FIN; a character after an error skips straight to S_FIN
        if (r_state == S_FIN && !r_last) w_cmd.rd_start = 1'b1;
    end

    assign o_cmd   = w_cmd;
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_err    <= ST_OK;
            r_drain  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            r_state <= n_state;
            r_err   <= n_err;
            r_drain <= n_drain;
            if (r_state == S_IDLE && i_valid) begin
                r_ch    <= i_data.char_code;
                r_last  <= i_data.last_char;
            end
            if (r_state == S_OUT && i_sts.tops_ok && !r_ovalid) begin
                r_ovalid     <= 1'b1;
                r_out.status <= r_err;
                r_out.value  <= (r_err == ST_OK) ? i_bottom : 32'sd0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;
endmodule

### sv/infix_expression_evaluator.sv
// Top level: infix expression evaluator with operand and operator stacks
//
// Input channel: one character per transfer (i_valid / o_stall), bundled
// with last_char which closes an expression. Output channel: one result
// per expression (o_valid / i_stall) holding value and status.
// Each character takes a decode plus a top-of-stack read from the stack
// RAMs. Every reduction adds a top read and one ALU pass: + and - need
// a single add or subtract, * and / run the bit-serial multiply and
// divide loop. The closing character drains all open operators the same
// way, then reads the bottom value.
// The result sits in an output register; a stall from the receiver holds
// it, and the next expression waits only if a new result is ready first.
// Reset empties both stacks and clears the error status; stack contents
// are left as they are. After a result both stacks are emptied again.
module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] bottom;

    iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts), .o_bottom(bottom));

    iee_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_cmd(cmd), .i_sts(sts), .i_bottom(bottom),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data));
endmodule

### sv/iee_checker.sv
// Port-level checker for the infix expression evaluator, bound to the top level
module iee_checker
    import iee_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_out o_data,
    input logic o_valid,
    input logic i_stall
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");
    a_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.value == 32'sd0)
        else $error("error result with nonzero value");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted two characters back to back");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule

bind infix_expression_evaluator iee_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_data(o_data), .o_valid(o_valid), .i_stall(i_stall));
